FILE: rtl/core/skt_pkg.sv
`default_nettype none

package skt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int REC_W       = 64;
    localparam int KMER_LSB    = 10;
    localparam int KMER_W      = 54;
    localparam int TAG_LSB     = 5;
    localparam int TAG_W       = 5;
    localparam int COUNT_W     = 5;
    localparam int LETTER_W    = 4;
    localparam int INDEX_W     = 10;
    localparam int ENTRY_CNT_W = 11;

    // transaction kinds on the mode input
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // command queue between front and back
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                 is_lookup;
        logic [IDX_W-1:0]     idx;
        logic [REC_W-1:0]     rec;
        logic [KMER_W-1:0]    key;
        logic [TAG_W-1:0]     want;
    } skt_cmd_t;

    typedef struct packed {
        logic [QCNT_W-1:0]    count;
        logic                 full;
        logic                 empty;
    } skt_q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/skt_front.sv
`default_nettype none

// Input stage: registers a transaction, forms the search tag and drops
// writes aimed past the table.
module skt_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              mode,
    input  wire logic [skt_pkg::INDEX_W-1:0]       index,
    input  wire logic [skt_pkg::REC_W-1:0]         record_word,
    input  wire logic [skt_pkg::KMER_W-1:0]        key_kmer,
    input  wire logic                              side,
    input  wire logic [skt_pkg::LETTER_W-1:0]      letter,
    output logic                                   push_valid,
    output skt_pkg::skt_cmd_t                      push_cmd,
    input  wire logic                              q_full
);

    logic              valid_reg;
    skt_pkg::skt_cmd_t cmd_reg;
    logic              take;
    logic              push_done;
    logic              keep;

    assign push_done = valid_reg && !q_full;
    assign in_stall  = valid_reg && q_full;
    assign take      = in_valid && !in_stall;
    // a write past the table is consumed without effect
    assign keep      = (mode == skt_pkg::OP_LOOKUP)
                    || (32'(index) < 32'(skt_pkg::TABLE_DEPTH));

    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= keep;
        end
        else if (push_done)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.is_lookup <= (mode == skt_pkg::OP_LOOKUP);
            cmd_reg.idx       <= skt_pkg::IDX_W'(index);
            cmd_reg.rec       <= record_word;
            cmd_reg.key       <= key_kmer;
            cmd_reg.want      <= {side, letter};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/skt_queue.sv
`default_nettype none

// Short command FIFO, fall-through read.
module skt_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire skt_pkg::skt_cmd_t     push_cmd,
    input  wire logic                  pop,
    output skt_pkg::skt_cmd_t          head_cmd,
    output skt_pkg::skt_q_status_t     status
);

    skt_pkg::skt_cmd_t                 slot_reg [skt_pkg::QDEPTH];
    logic [skt_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [skt_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [skt_pkg::QCNT_W-1:0]        count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == skt_pkg::QCNT_W'(skt_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    function automatic logic [skt_pkg::QPTR_W-1:0] bump(input logic [skt_pkg::QPTR_W-1:0] p);
        if (p == skt_pkg::QPTR_W'(skt_pkg::QDEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/skt_back.sv
`default_nettype none

// Table memory, binary search, neighbour scan and result register.
module skt_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [skt_pkg::CNT_W-1:0]     n,
    input  wire logic                          q_ready,
    input  wire skt_pkg::skt_cmd_t             q_cmd,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [skt_pkg::COUNT_W-1:0]        overlap_count,
    output logic                               busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PROBE_CMP,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_DONE
    } state_t;

    state_t                             state_reg;
    logic [skt_pkg::CNT_W-1:0]          lo_reg;
    logic [skt_pkg::CNT_W-1:0]          hi_reg;     // one past the upper bound
    logic [skt_pkg::CNT_W-1:0]          pos_reg;
    logic [skt_pkg::KMER_W-1:0]         key_reg;
    logic [skt_pkg::TAG_W-1:0]          want_reg;
    logic                               up_reg;
    logic                               hit_reg;
    logic [skt_pkg::COUNT_W-1:0]        cnt_reg;
    logic                               out_valid_reg;
    logic                               found_reg;
    logic [skt_pkg::COUNT_W-1:0]        overlap_reg;

    logic [skt_pkg::REC_W-1:0]          mem [skt_pkg::TABLE_DEPTH];
    logic [skt_pkg::REC_W-1:0]          rd_data_reg;

    logic                               wr_en;
    logic                               rd_en;
    logic [skt_pkg::IDX_W-1:0]          rd_addr;
    logic [skt_pkg::CNT_W:0]            mid_sum;
    logic [skt_pkg::CNT_W-1:0]          mid;
    logic                               probe_live;
    logic [skt_pkg::CNT_W-1:0]          scan_pos;
    logic                               scan_live;
    logic [skt_pkg::KMER_W-1:0]         rd_kmer;
    logic [skt_pkg::TAG_W-1:0]          rd_tag;
    logic [skt_pkg::COUNT_W-1:0]        rd_cnt;
    logic                               out_free;

    assign rd_kmer = rd_data_reg[skt_pkg::KMER_LSB +: skt_pkg::KMER_W];
    assign rd_tag  = rd_data_reg[skt_pkg::TAG_LSB +: skt_pkg::TAG_W];
    assign rd_cnt  = rd_data_reg[skt_pkg::COUNT_W-1:0];

    assign q_pop = (state_reg == ST_IDLE) && q_ready;
    assign wr_en = q_pop && !q_cmd.is_lookup;
    assign busy  = (state_reg != ST_IDLE);

    assign probe_live = (lo_reg < hi_reg);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid        = mid_sum[skt_pkg::CNT_W:1];

    assign scan_pos  = up_reg ? (pos_reg + 1'b1) : (pos_reg - 1'b1);
    assign scan_live = up_reg ? (scan_pos < n) : (pos_reg != '0);

    assign rd_en   = ((state_reg == ST_PROBE) && probe_live)
                  || ((state_reg == ST_SCAN) && scan_live);
    assign rd_addr = (state_reg == ST_PROBE) ? mid[skt_pkg::IDX_W-1:0]
                                             : scan_pos[skt_pkg::IDX_W-1:0];

    assign out_free      = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign overlap_count = overlap_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_cmd.idx] <= q_cmd.rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            pos_reg       <= '0;
            key_reg       <= '0;
            want_reg      <= '0;
            up_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            overlap_reg   <= '0;
        end
        else
        begin
            // in ST_DONE the result register is reloaded below instead
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop && q_cmd.is_lookup)
                    begin
                        key_reg   <= q_cmd.key;
                        want_reg  <= q_cmd.want;
                        lo_reg    <= '0;
                        hi_reg    <= n;
                        state_reg <= ST_PROBE;
                    end
                end

                ST_PROBE:
                begin
                    if (probe_live)
                    begin
                        pos_reg   <= mid;
                        state_reg <= ST_PROBE_CMP;
                    end
                    else
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end

                ST_PROBE_CMP:
                begin
                    if (rd_kmer == key_reg)
                    begin
                        if (rd_tag == want_reg)
                        begin
                            hit_reg   <= 1'b1;
                            cnt_reg   <= rd_cnt;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            up_reg    <= (rd_tag < want_reg);
                            state_reg <= ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (rd_kmer < key_reg)
                        begin
                            lo_reg <= pos_reg + 1'b1;
                        end
                        else
                        begin
                            hi_reg <= pos_reg;
                        end
                        state_reg <= ST_PROBE;
                    end
                end

                ST_SCAN:
                begin
                    if (scan_live)
                    begin
                        pos_reg   <= scan_pos;
                        state_reg <= ST_SCAN_CMP;
                    end
                    else
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end

                ST_SCAN_CMP:
                begin
                    if (rd_kmer != key_reg)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else if (rd_tag == want_reg)
                    begin
                        hit_reg   <= 1'b1;
                        cnt_reg   <= rd_cnt;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        overlap_reg   <= hit_reg ? cnt_reg : '0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_kmer_table_lookup.sv
`default_nettype none

// Sorted k-mer table lookup. The table holds TABLE_DEPTH 64-bit records
// sorted by value (k-mer in bits 63..10, tag in 9..5, count in 4..0). A
// transaction with mode 0 writes record_word at index and returns nothing;
// mode 1 searches the first entry_count records for key_kmer with tag
// {side, letter} and returns one transaction with found and overlap_count
// (0 when not found). entry_count above the table depth counts as the depth.
// Flow: the front stage registers each transaction and passes it through a
// two-entry command queue to the back end, which serves one command at a
// time from a single-port table memory with registered read data. A write
// is done as the command leaves the queue; the back end stays idle. A lookup
// runs search probes (at most 11 probes for 1024 entries), then scans
// same-k-mer neighbours, then loads the result register; each probe and each
// neighbour scanned is one read of the table memory port and a compare. The
// result register lets the next command start while a result waits on
// out_stall. Records read before they were written return undefined data.
// entry_count may be changed only while no lookup is outstanding.
module sorted_kmer_table_lookup (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [skt_pkg::ENTRY_CNT_W-1:0]       cfg_wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  mode,
    input  wire logic [skt_pkg::INDEX_W-1:0]           index,
    input  wire logic [skt_pkg::REC_W-1:0]             record_word,
    input  wire logic [skt_pkg::KMER_W-1:0]            key_kmer,
    input  wire logic                                  side,
    input  wire logic [skt_pkg::LETTER_W-1:0]          letter,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       found,
    output logic [skt_pkg::COUNT_W-1:0]                overlap_count
);

    logic [skt_pkg::ENTRY_CNT_W-1:0]   entry_count_reg;
    logic [skt_pkg::CNT_W-1:0]         n_sat;

    logic                              push_valid;
    skt_pkg::skt_cmd_t                 push_cmd;
    skt_pkg::skt_cmd_t                 head_cmd;
    skt_pkg::skt_q_status_t            q_status;
    logic                              q_pop;
    logic                              back_busy;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // clamp the entry count to the table depth
    assign n_sat = (32'(entry_count_reg) > 32'(skt_pkg::TABLE_DEPTH))
                 ? skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH)
                 : skt_pkg::CNT_W'(entry_count_reg);

    skt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .index       (index),
        .record_word (record_word),
        .key_kmer    (key_kmer),
        .side        (side),
        .letter      (letter),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .q_full      (q_status.full)
    );

    skt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    skt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .n             (n_sat),
        .q_ready       (!q_status.empty),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .overlap_count (overlap_count),
        .busy          (back_busy)
    );

    // a miss always reports a zero count
    a_miss_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> overlap_count == '0)
        else $error("miss with non-zero overlap_count");

    // a new result only comes out of a running lookup
    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_busy))
        else $error("result appeared without a lookup in progress");

    // queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(q_status.count) <= 32'(skt_pkg::QDEPTH))
        else $error("command queue overflow");

endmodule

`default_nettype wire

FILE: tb/tb_sorted_kmer_table_lookup.sv
`timescale 1ns / 1ps

module tb_sorted_kmer_table_lookup;

    // settle time after the last answer: queued writes still drain through
    // the front stage and command queue without producing anything
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                        found;
        logic [skt_pkg::COUNT_W-1:0] count;
    } lookup_answer_t;

    // Mirror of the table plus the queue of answers still owed by the block.
    class kmer_lookup_tracker;
        logic [skt_pkg::REC_W-1:0] slots [skt_pkg::TABLE_DEPTH];
        int unsigned               entry_count;
        lookup_answer_t            owed [$];
        int                        errors;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            entry_count = 0;
            errors = 0;
        endfunction

        function void set_entry_count(int unsigned value);
            entry_count = value;
        endfunction

        // binary search on the k-mer, then walk same-k-mer neighbours
        function lookup_answer_t search_table(logic [skt_pkg::KMER_W-1:0] key,
                                              logic [skt_pkg::TAG_W-1:0] want);
            int                        lo;
            int                        hi;
            int                        pos;
            int                        n;
            int                        step;
            bit                        hit;
            bit                        walking;
            logic [skt_pkg::REC_W-1:0] rec;
            lookup_answer_t            ans;
            n = (entry_count > skt_pkg::TABLE_DEPTH) ? skt_pkg::TABLE_DEPTH : entry_count;
            lo = 0;
            hi = n - 1;
            pos = 0;
            hit = 0;
            rec = '0;
            while (!hit && lo <= hi)
            begin
                pos = (lo + hi) / 2;
                rec = slots[pos];
                if (rec[skt_pkg::REC_W-1:skt_pkg::KMER_LSB] == key)
                    hit = 1;
                else if (rec[skt_pkg::REC_W-1:skt_pkg::KMER_LSB] < key)
                    lo = pos + 1;
                else
                    hi = pos - 1;
            end
            if (hit && rec[skt_pkg::TAG_LSB +: skt_pkg::TAG_W] != want)
            begin
                step = (rec[skt_pkg::TAG_LSB +: skt_pkg::TAG_W] < want) ? 1 : -1;
                walking = 1;
                while (walking)
                begin
                    pos = pos + step;
                    if (pos < 0 || pos >= n)
                    begin
                        hit = 0;
                        walking = 0;
                    end
                    else
                    begin
                        rec = slots[pos];
                        if (rec[skt_pkg::REC_W-1:skt_pkg::KMER_LSB] != key)
                        begin
                            hit = 0;
                            walking = 0;
                        end
                        else if (rec[skt_pkg::TAG_LSB +: skt_pkg::TAG_W] == want)
                            walking = 0;
                    end
                end
            end
            ans.found = hit;
            ans.count = hit ? rec[skt_pkg::COUNT_W-1:0] : '0;
            return ans;
        endfunction

        function void take_transaction(logic m, logic [skt_pkg::INDEX_W-1:0] idx,
                                       logic [skt_pkg::REC_W-1:0] rec,
                                       logic [skt_pkg::KMER_W-1:0] key,
                                       logic s, logic [skt_pkg::LETTER_W-1:0] ltr);
            if (m == skt_pkg::OP_WRITE)
                slots[idx] = rec;
            else
                owed.push_back(search_table(key, {s, ltr}));
        endfunction

        function void check_answer(logic f, logic [skt_pkg::COUNT_W-1:0] c);
            lookup_answer_t exp_ans;
            if (owed.size() == 0)
            begin
                $error("result with no lookup outstanding: found %0d count %0d", f, c);
                errors++;
            end
            else
            begin
                exp_ans = owed.pop_front();
                if (f !== exp_ans.found)
                begin
                    $error("found: expected %0d, actual %0d", exp_ans.found, f);
                    errors++;
                end
                if (c !== exp_ans.count)
                begin
                    $error("overlap_count: expected %0d, actual %0d", exp_ans.count, c);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [skt_pkg::ENTRY_CNT_W-1:0] cfg_wr_data;
    logic                            in_valid;
    logic                            in_stall;
    logic                            mode;
    logic [skt_pkg::INDEX_W-1:0]     index;
    logic [skt_pkg::REC_W-1:0]       record_word;
    logic [skt_pkg::KMER_W-1:0]      key_kmer;
    logic                            side;
    logic [skt_pkg::LETTER_W-1:0]    letter;
    logic                            out_valid;
    logic                            out_stall;
    logic                            found;
    logic [skt_pkg::COUNT_W-1:0]     overlap_count;

    kmer_lookup_tracker tracker;
    bit                 quiet;       // no idling on either side when set
    int                 sent_items;

    sorted_kmer_table_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .index         (index),
        .record_word   (record_word),
        .key_kmer      (key_kmer),
        .side          (side),
        .letter        (letter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .overlap_count (overlap_count)
    );

    always #5 clk = ~clk;

    // Every accepted result goes straight to the tracker; values are taken
    // at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_answer(found, overlap_count);
    end

    // Receiver back-pressure: random stall bursts, switched off whenever quiet
    // is set.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high, so back-to-back transactions need no dip.
    task automatic send_item(logic m, logic [skt_pkg::INDEX_W-1:0] idx,
                             logic [skt_pkg::REC_W-1:0] rec,
                             logic [skt_pkg::KMER_W-1:0] key, logic s,
                             logic [skt_pkg::LETTER_W-1:0] ltr);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        mode        <= m;
        index       <= idx;
        record_word <= rec;
        key_kmer    <= key;
        side        <= s;
        letter      <= ltr;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_transaction(m, idx, rec, key, s, ltr);
        sent_items++;
        @(negedge clk);
    endtask

    // unused fields of each kind of transaction carry random junk
    task automatic write_slot(logic [skt_pkg::INDEX_W-1:0] idx,
                              logic [skt_pkg::REC_W-1:0] rec);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_item(skt_pkg::OP_WRITE, idx, rec, junk[skt_pkg::KMER_W-1:0], junk[63],
                  junk[62:59]);
    endtask

    task automatic lookup(logic [skt_pkg::KMER_W-1:0] key, logic [skt_pkg::TAG_W-1:0] tag);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_item(skt_pkg::OP_LOOKUP, junk[63:54], {$urandom, $urandom}, key, tag[4],
                  tag[3:0]);
    endtask

    // Sender pause: nothing new goes in until every owed answer is back and
    // any trailing writes have drained.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // only ever called after reset or after settle(), with the block idle
    task automatic write_entry_count(logic [skt_pkg::ENTRY_CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        tracker.set_entry_count(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Load slots 0..n-1 with records drawn from a pool of k-mers, so that
    // same-k-mer runs occur; normally sorted, optionally left in draw order.
    task automatic fill_table(int n, bit sorted);
        logic [skt_pkg::KMER_W-1:0] pool [256];
        logic [skt_pkg::REC_W-1:0]  recs [skt_pkg::TABLE_DEPTH];
        logic [63:0]                v;
        logic [skt_pkg::REC_W-1:0]  hold;
        int                         g_lo;
        int                         g_hi;
        int                         g;
        int                         j;
        g_lo = (n / 4 > 1) ? n / 4 : 1;
        g_hi = (n / 2 > 1) ? n / 2 : 1;
        if (g_hi > 256)
            g_hi = 256;
        if (g_lo > g_hi)
            g_lo = g_hi;
        g = $urandom_range(g_lo, g_hi);
        for (int i = 0; i < g; i++)
        begin
            v = {$urandom, $urandom};
            pool[i] = ($urandom_range(0, 3) == 0)
                    ? skt_pkg::KMER_W'($urandom_range(0, 20))
                    : v[skt_pkg::KMER_W-1:0];
        end
        for (int i = 0; i < n; i++)
        begin
            v = {$urandom, $urandom};
            recs[i] = {pool[$urandom_range(0, g - 1)], v[9:0]};
        end
        if (sorted)
        begin
            for (int i = 1; i < n; i++)
            begin
                hold = recs[i];
                j = i - 1;
                while (j >= 0 && recs[j] > hold)
                begin
                    recs[j + 1] = recs[j];
                    j--;
                end
                recs[j + 1] = hold;
            end
        end
        for (int i = 0; i < n; i++)
            write_slot(skt_pkg::INDEX_W'(i), recs[i]);
    endtask

    // Mostly keys and tags taken from live entries (hits and near misses
    // on the tag), otherwise neighbouring or wholly random k-mers.
    task automatic random_lookup();
        logic [63:0]                v;
        logic [skt_pkg::REC_W-1:0]  rec;
        logic [skt_pkg::KMER_W-1:0] key;
        logic [skt_pkg::TAG_W-1:0]  want;
        int                         n;
        v = {$urandom, $urandom};
        key = v[63:10];
        want = v[4:0];
        n = (tracker.entry_count > skt_pkg::TABLE_DEPTH) ? skt_pkg::TABLE_DEPTH
                                                         : tracker.entry_count;
        if (n > 0 && $urandom_range(0, 9) < 8)
        begin
            rec = tracker.slots[$urandom_range(0, n - 1)];
            key = rec[skt_pkg::REC_W-1:skt_pkg::KMER_LSB];
            if ($urandom_range(0, 2) != 0)
                want = rec[skt_pkg::TAG_LSB +: skt_pkg::TAG_W];
            if ($urandom_range(0, 7) == 0)
                key = ($urandom_range(0, 1) == 0) ? key + 1'b1 : key - 1'b1;
        end
        lookup(key, want);
    endtask

    // stray write during a lookup phase: re-count an entry or hit any slot
    task automatic random_write();
        logic [63:0]               v;
        logic [skt_pkg::REC_W-1:0] rec;
        int                        n;
        int                        s;
        v = {$urandom, $urandom};
        n = (tracker.entry_count > skt_pkg::TABLE_DEPTH) ? skt_pkg::TABLE_DEPTH
                                                         : tracker.entry_count;
        if (n > 0 && $urandom_range(0, 1) == 0)
        begin
            s = $urandom_range(0, n - 1);
            rec = tracker.slots[s];
            rec[skt_pkg::COUNT_W-1:0] = v[skt_pkg::COUNT_W-1:0];
            write_slot(skt_pkg::INDEX_W'(s), rec);
        end
        else
            write_slot(skt_pkg::INDEX_W'($urandom_range(0, skt_pkg::TABLE_DEPTH - 1)), v);
    endtask

    task automatic lookup_burst(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 6) == 0)
                random_write();
            else
                random_lookup();
        end
    endtask

    initial
    begin
        int n;
        int phase_start;
        logic [skt_pkg::REC_W-1:0] all_ones;
        tracker     = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        mode        = skt_pkg::OP_WRITE;
        index       = '0;
        record_word = '0;
        key_kmer    = '0;
        side        = 1'b0;
        letter      = '0;
        out_stall   = 1'b0;
        quiet       = 1'b0;
        sent_items  = 0;
        all_ones    = '1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part ---
        // empty table answers not found
        write_entry_count('0);
        lookup('0, '0);
        settle();

        // small sorted table: k-mer 0 at both tag extremes, a run of four
        // k-mer 5 records, and the all-ones record at the top
        write_slot(0, '0);
        write_slot(1, {skt_pkg::KMER_W'(0), 5'd31, 5'd31});
        write_slot(2, {skt_pkg::KMER_W'(5), 5'd3, 5'd7});
        write_slot(3, {skt_pkg::KMER_W'(5), 5'd9, 5'd12});
        write_slot(4, {skt_pkg::KMER_W'(5), 5'd17, 5'd20});
        write_slot(5, {skt_pkg::KMER_W'(5), 5'd30, 5'd1});
        write_slot(6, all_ones);
        settle();
        write_entry_count(7);
        lookup(skt_pkg::KMER_W'(5), 5'd9);      // direct hit on the first probe
        lookup(skt_pkg::KMER_W'(5), 5'd17);     // upward walk
        lookup(skt_pkg::KMER_W'(5), 5'd30);     // upward walk, two steps
        lookup(skt_pkg::KMER_W'(5), 5'd3);      // downward walk
        lookup(skt_pkg::KMER_W'(5), 5'd31);     // upward walk runs into another k-mer
        lookup(skt_pkg::KMER_W'(0), 5'd0);
        lookup(skt_pkg::KMER_W'(0), 5'd31);
        lookup(skt_pkg::KMER_W'(0), 5'd16);     // downward walk falls off slot 0
        lookup('1, 5'd31);
        lookup('1, 5'd20);                      // downward walk runs into another k-mer
        lookup(skt_pkg::KMER_W'(3), 5'd9);      // k-mer absent
        settle();
        // with one live entry the upward walk hits the end of the table
        write_entry_count(1);
        lookup(skt_pkg::KMER_W'(0), 5'd31);
        lookup(skt_pkg::KMER_W'(0), 5'd0);
        settle();

        // --- random phases: fresh table, new count, then mixed traffic ---
        phase_start = sent_items;
        while (sent_items - phase_start < 600)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            fill_table(n, $urandom_range(0, 7) != 0);
            settle();
            if ($urandom_range(0, 3) == 0)
                write_entry_count(skt_pkg::ENTRY_CNT_W'($urandom_range(0, n)));
            else
                write_entry_count(skt_pkg::ENTRY_CNT_W'(n));
            lookup_burst($urandom_range(10, 40));
            settle();
        end

        // --- last part, no idling: full table and counts at and past the depth ---
        quiet = 1'b1;
        fill_table(skt_pkg::TABLE_DEPTH, 1'b1);
        settle();
        write_entry_count('1);
        lookup_burst(40);
        settle();
        write_entry_count(skt_pkg::ENTRY_CNT_W'(skt_pkg::TABLE_DEPTH));
        lookup_burst(20);
        settle();
        write_entry_count(skt_pkg::ENTRY_CNT_W'($urandom_range(skt_pkg::TABLE_DEPTH + 1,
                                                               2046)));
        lookup_burst(20);
        settle();

        if (tracker.errors == 0 && tracker.owed.size() == 0)
            $display("tb_sorted_kmer_table_lookup OK");
        else
            $display("tb_sorted_kmer_table_lookup NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #(64'd10_000_000);
        $display("tb_sorted_kmer_table_lookup NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/skt_pkg.sv
rtl/core/skt_front.sv
rtl/core/skt_queue.sv
rtl/core/skt_back.sv
rtl/core/sorted_kmer_table_lookup.sv
tb/tb_sorted_kmer_table_lookup.sv
